// ===== rtl/htss_pkg.sv =====
// Shared types, codes and constants for the humidity/temperature sensor sequencer.
// Used by htss_seq, htss_avg and humidity_temp_sensor_sequencer.
package htss_pkg;

   localparam int HISTORY_DEPTH_DEFAULT = 3;
   localparam int SAMPLE_WIDTH          = 20;
   localparam int CSR_INDEX_WIDTH       = 3;
   localparam int CSR_DATA_WIDTH        = 8;
   localparam int SCALE_WIDTH           = 11;
   localparam int PROD_WIDTH            = SAMPLE_WIDTH + SCALE_WIDTH;

   localparam logic [SCALE_WIDTH-1:0] TEMP_SCALE  = 11'd2000;
   localparam logic [SCALE_WIDTH-1:0] HUM_SCALE   = 11'd1000;
   localparam logic [PROD_WIDTH-1:0]  ROUND_HALF  = 31'd524288;
   localparam logic [11:0]            TEMP_OFFSET = 12'd500;
   localparam logic [7:0]             TICK_MAX    = 8'hFF;

   typedef enum logic [1:0] {
      REQ_TICK      = 2'd0,
      REQ_INIT_DONE = 2'd1,
      REQ_TRIG_DONE = 2'd2,
      REQ_READ_DONE = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      CMD_NONE = 2'd0,
      CMD_INIT = 2'd1,
      CMD_TRIG = 2'd2,
      CMD_READ = 2'd3
   } cmd_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_BOOT_WAIT    = 3'd0,
      CSR_INIT_WAIT    = 3'd1,
      CSR_CONVERT_WAIT = 3'd2,
      CSR_POLL_WAIT    = 3'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_BOOT      = 3'd0,
      PH_INIT      = 3'd1,
      PH_CONVERT   = 3'd2,
      PH_POLL      = 3'd3,
      PH_WAIT_INIT = 3'd4,
      PH_WAIT_TRIG = 3'd5,
      PH_WAIT_READ = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      AVG_IDLE,
      AVG_SUM,
      AVG_DIV,
      AVG_SCALE,
      AVG_DONE
   } avg_state_type;

   typedef enum logic {
      TOP_IDLE,
      TOP_CALC
   } top_state_type;

   typedef struct packed {
      logic [7:0] boot_wait;
      logic [7:0] init_wait;
      logic [7:0] convert_wait;
      logic [7:0] poll_wait;
   } wait_cfg_type;

   typedef struct packed {
      cmd_type command;
      logic    read_ok;
      logic    read_fail;
   } seq_event_type;

   typedef struct packed {
      logic signed [11:0] temp_tenths;
      logic [9:0]         hum_tenths;
   } avg_result_type;

   function automatic logic [SAMPLE_WIDTH-1:0] unpack_temp(
      input logic [7:0] b3, input logic [7:0] b4, input logic [7:0] b5);
      return {b3[3:0], b4, b5};
   endfunction

   function automatic logic [SAMPLE_WIDTH-1:0] unpack_hum(
      input logic [7:0] b1, input logic [7:0] b2, input logic [7:0] b3);
      return {b1, b2, b3[7:4]};
   endfunction

endpackage

// ===== rtl/htss_seq.sv =====
// Sensor phase sequencer: phase state machine and saturating tick counter.
// Decides the bus command and read outcome for each accepted event; uses htss_pkg.
module htss_seq import htss_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  logic [1:0]    req_type,
   input  logic          xfer_ok,
   input  wait_cfg_type  waits,
   output seq_event_type ev
);

   phase_type  phase_ff, phase_in;
   logic [7:0] tick_ff, tick_in;
   logic [7:0] tick_sat;
   logic       tick_ev, init_ev, trig_ev, read_ev;
   logic       wait_done;

   assign tick_sat = (tick_ff == TICK_MAX) ? TICK_MAX : tick_ff + 8'd1;
   assign tick_ev  = (req_type == REQ_TICK);
   assign init_ev  = (req_type == REQ_INIT_DONE) && (phase_ff == PH_WAIT_INIT);
   assign trig_ev  = (req_type == REQ_TRIG_DONE) && (phase_ff == PH_WAIT_TRIG);
   assign read_ev  = (req_type == REQ_READ_DONE) && (phase_ff == PH_WAIT_READ);

   always_comb begin
      case (phase_ff)
         PH_BOOT:    wait_done = tick_sat >= waits.boot_wait;
         PH_INIT:    wait_done = tick_sat >= waits.init_wait;
         PH_CONVERT: wait_done = tick_sat >= waits.convert_wait;
         PH_POLL:    wait_done = tick_sat >= waits.poll_wait;
         default:    wait_done = 1'b0;
      endcase
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (tick_ev && wait_done) begin
         case (phase_ff)
            PH_BOOT:    phase_in = PH_WAIT_INIT;
            PH_INIT:    phase_in = PH_WAIT_TRIG;
            PH_CONVERT: phase_in = PH_WAIT_READ;
            PH_POLL:    phase_in = PH_WAIT_TRIG;
            default:    phase_in = phase_ff;
         endcase
      end else if (init_ev) begin
         phase_in = xfer_ok ? PH_INIT : PH_BOOT;
      end else if (trig_ev) begin
         phase_in = xfer_ok ? PH_CONVERT : PH_BOOT;
      end else if (read_ev) begin
         phase_in = xfer_ok ? PH_POLL : PH_BOOT;
      end
   end

   // outputs
   always_comb begin
      ev.command   = CMD_NONE;
      ev.read_ok   = read_ev && xfer_ok;
      ev.read_fail = read_ev && !xfer_ok;
      if (tick_ev && wait_done) begin
         case (phase_ff)
            PH_BOOT:    ev.command = CMD_INIT;
            PH_INIT:    ev.command = CMD_TRIG;
            PH_CONVERT: ev.command = CMD_READ;
            PH_POLL:    ev.command = CMD_TRIG;
            default:    ev.command = CMD_NONE;
         endcase
      end
   end

   always_comb begin
      tick_in = tick_ff;
      if (tick_ev) begin
         tick_in = wait_done ? 8'd0 : tick_sat;
      end else if ((init_ev || trig_ev || read_ev) && xfer_ok) begin
         tick_in = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_BOOT;
         tick_ff  <= 8'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
      end
   end

endmodule

// ===== rtl/htss_avg.sv =====
// Sample history and iterative averaging engine: one adder for the sum, a
// bit-serial restoring divider and one multiplier for scaling; uses htss_pkg.
module htss_avg import htss_pkg::*; #(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    clear,
   input  logic [SAMPLE_WIDTH-1:0] temp_sample,
   input  logic [SAMPLE_WIDTH-1:0] hum_sample,
   input  logic                    ack,
   output logic                    done,
   output avg_result_type          result
);

   localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
   localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int SUM_W = SAMPLE_WIDTH + $clog2(HISTORY_DEPTH);
   localparam int BIT_W = $clog2(SUM_W + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(HISTORY_DEPTH);

   logic [SAMPLE_WIDTH-1:0] temp_hist_ff [HISTORY_DEPTH];
   logic [SAMPLE_WIDTH-1:0] hum_hist_ff  [HISTORY_DEPTH];

   avg_state_type       state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    left_ff, left_in;
   logic [CNT_W-1:0]    idx_full;
   logic [IDX_W-1:0]    idx;
   logic [SUM_W-1:0]    acc_ff, acc_in;
   logic [CNT_W-1:0]    rem_ff, rem_in;
   logic [CNT_W:0]      rem_sh;
   logic                fits;
   logic [BIT_W-1:0]    bit_ff, bit_in;
   logic                chan_ff, chan_in;
   logic [SAMPLE_WIDTH-1:0] entry;
   logic [SCALE_WIDTH-1:0]  coef;
   logic [PROD_WIDTH-1:0]   prod;
   logic [SCALE_WIDTH-1:0]  scaled;
   avg_result_type      result_ff, result_in;

   always_comb begin
      if (clear) begin
         count_in = '0;
      end else if (start && count_ff != DEPTH_CNT) begin
         count_in = count_ff + CNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   assign idx_full = DEPTH_CNT - left_ff;
   assign idx      = idx_full[IDX_W-1:0];
   assign entry    = chan_ff ? hum_hist_ff[idx] : temp_hist_ff[idx];
   assign rem_sh   = {rem_ff, acc_ff[SUM_W-1]};
   assign fits     = rem_sh >= {1'b0, count_ff};
   assign coef     = chan_ff ? HUM_SCALE : TEMP_SCALE;
   assign prod     = PROD_WIDTH'(acc_ff[SAMPLE_WIDTH-1:0]) * PROD_WIDTH'(coef) + ROUND_HALF;
   assign scaled   = prod[PROD_WIDTH-1 -: SCALE_WIDTH];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         AVG_IDLE:  if (start) state_in = AVG_SUM;
         AVG_SUM:   if (left_ff == CNT_W'(1)) state_in = AVG_DIV;
         AVG_DIV:   if (bit_ff == BIT_W'(1)) state_in = AVG_SCALE;
         AVG_SCALE: state_in = chan_ff ? AVG_DONE : AVG_SUM;
         AVG_DONE:  if (ack) state_in = AVG_IDLE;
         default:   state_in = AVG_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      left_in   = left_ff;
      acc_in    = acc_ff;
      rem_in    = rem_ff;
      bit_in    = bit_ff;
      chan_in   = chan_ff;
      result_in = result_ff;
      case (state_ff)
         AVG_IDLE: begin
            left_in = count_in;
            acc_in  = '0;
            chan_in = 1'b0;
         end
         AVG_SUM: begin
            acc_in  = acc_ff + SUM_W'(entry);
            left_in = left_ff - CNT_W'(1);
            rem_in  = '0;
            bit_in  = BIT_W'(SUM_W);
         end
         AVG_DIV: begin
            rem_in = fits ? CNT_W'(rem_sh - {1'b0, count_ff}) : rem_sh[CNT_W-1:0];
            acc_in = {acc_ff[SUM_W-2:0], fits};
            bit_in = bit_ff - BIT_W'(1);
         end
         AVG_SCALE: begin
            if (chan_ff) begin
               result_in.hum_tenths = scaled[9:0];
            end else begin
               result_in.temp_tenths = $signed({1'b0, scaled} - TEMP_OFFSET);
            end
            chan_in = 1'b1;
            left_in = count_ff;
            acc_in  = '0;
         end
         default: begin
            left_in = left_ff;
         end
      endcase
   end

   assign done   = (state_ff == AVG_DONE);
   assign result = result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= AVG_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff   <= left_in;
      acc_ff    <= acc_in;
      rem_ff    <= rem_in;
      bit_ff    <= bit_in;
      chan_ff   <= chan_in;
      result_ff <= result_in;
      if (start) begin
         for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
            temp_hist_ff[i] <= temp_hist_ff[i + 1];
            hum_hist_ff[i]  <= hum_hist_ff[i + 1];
         end
         temp_hist_ff[HISTORY_DEPTH - 1] <= temp_sample;
         hum_hist_ff[HISTORY_DEPTH - 1]  <= hum_sample;
      end
   end

endmodule

// ===== rtl/humidity_temp_sensor_sequencer.sv =====
// Humidity/temperature sensor sequencer, top level: configuration registers,
// transfer handshakes and result register. Uses htss_pkg, htss_seq and htss_avg.
//
// Usage: each transfer on the req_ channel is one event (tick, init sent,
// trigger sent, read done) and gives exactly one transfer on the rsp_ channel
// carrying the bus command to issue, and on a good read the averaged reading.
// Ticks, command completions and failed reads are answered at the edge they are
// accepted: the result is registered there and req_ready stays high, so these
// events can be taken every cycle as long as the result is taken.
// A good read pushes the sample into the history and runs the averaging engine:
// per channel (temperature, then humidity) it sums the valid entries one per
// cycle, divides one quotient bit per cycle and scales with one multiplier;
// req_ready is low until the averaged reading is loaded into the result register.
// The csr_ port writes one of the four wait registers, chosen by csr_index; indexes
// beyond the list are ignored. Write it only while no event is in flight.
// Reset (synchronous) returns to the boot phase, clears the tick counter and
// history count and restores the default waits. While a result is pending and
// rsp_ready is low the result is held and no new event is taken.
module humidity_temp_sensor_sequencer import htss_pkg::*; #(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_type,
   input  logic                       req_xfer_ok,
   input  logic [7:0]                 req_rx_byte1,
   input  logic [7:0]                 req_rx_byte2,
   input  logic [7:0]                 req_rx_byte3,
   input  logic [7:0]                 req_rx_byte4,
   input  logic [7:0]                 req_rx_byte5,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [1:0]                 rsp_command,
   output logic                       rsp_reading_valid,
   output logic signed [11:0]         rsp_temp_tenths,
   output logic [9:0]                 rsp_hum_tenths,
   output logic                       rsp_read_error,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   wait_cfg_type   waits_ff;
   top_state_type  state_ff, state_in;
   seq_event_type  ev;
   avg_result_type avg_res;
   logic           accept, out_free, avg_done, avg_start, avg_ack;
   logic           load_direct, load_avg;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [1:0]     command_ff;
   logic           reading_valid_ff, read_error_ff;
   logic signed [11:0] temp_ff;
   logic [9:0]     hum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         waits_ff.boot_wait    <= 8'd1;
         waits_ff.init_wait    <= 8'd1;
         waits_ff.convert_wait <= 8'd2;
         waits_ff.poll_wait    <= 8'd50;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BOOT_WAIT:    waits_ff.boot_wait    <= csr_wdata;
            CSR_INIT_WAIT:    waits_ff.init_wait    <= csr_wdata;
            CSR_CONVERT_WAIT: waits_ff.convert_wait <= csr_wdata;
            CSR_POLL_WAIT:    waits_ff.poll_wait    <= csr_wdata;
            default:          waits_ff <= waits_ff;
         endcase
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign accept   = req_valid && req_ready;

   htss_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_type (req_type),
      .xfer_ok  (req_xfer_ok),
      .waits    (waits_ff),
      .ev       (ev)
   );

   htss_avg #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_avg (
      .clock       (clock),
      .reset       (reset),
      .start       (avg_start),
      .clear       (accept && ev.read_fail),
      .temp_sample (unpack_temp(req_rx_byte3, req_rx_byte4, req_rx_byte5)),
      .hum_sample  (unpack_hum(req_rx_byte1, req_rx_byte2, req_rx_byte3)),
      .ack         (avg_ack),
      .done        (avg_done),
      .result      (avg_res)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         TOP_IDLE: if (accept && ev.read_ok) state_in = TOP_CALC;
         TOP_CALC: if (avg_done && out_free) state_in = TOP_IDLE;
         default:  state_in = TOP_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready   = 1'b0;
      avg_start   = 1'b0;
      avg_ack     = 1'b0;
      load_direct = 1'b0;
      load_avg    = 1'b0;
      case (state_ff)
         TOP_IDLE: begin
            req_ready   = out_free;
            avg_start   = accept && ev.read_ok;
            load_direct = accept && !ev.read_ok;
         end
         TOP_CALC: begin
            avg_ack  = avg_done && out_free;
            load_avg = avg_done && out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = (load_direct || load_avg) ? 1'b1 :
                         (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= TOP_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_direct) begin
         command_ff       <= ev.command;
         reading_valid_ff <= 1'b0;
         temp_ff          <= '0;
         hum_ff           <= '0;
         read_error_ff    <= ev.read_fail;
      end else if (load_avg) begin
         command_ff       <= CMD_NONE;
         reading_valid_ff <= 1'b1;
         temp_ff          <= avg_res.temp_tenths;
         hum_ff           <= avg_res.hum_tenths;
         read_error_ff    <= 1'b0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_command       = command_ff;
   assign rsp_reading_valid = reading_valid_ff;
   assign rsp_temp_tenths   = temp_ff;
   assign rsp_hum_tenths    = hum_ff;
   assign rsp_read_error    = read_error_ff;

endmodule
